>>> hw/rtl/sfm_pkg.sv
// Shared types, constants and codes for the seeder fault monitor.
package sfm_pkg;

    localparam int SENSOR_W      = 8;
    localparam int PLANTER_PER_W = 16;
    localparam int PACKER_PER_W  = 8;
    localparam int LEVEL_W       = 5;
    localparam int LEVEL_INT_W   = 8;
    localparam int SPEED_W       = 16;
    localparam int FAULT_W       = 3;
    localparam int RATIO_W       = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 8;
    localparam int PLANTER_NUM_W = 32;
    localparam int PACKER_NUM_W  = 16;
    localparam int LEVEL_MUL_W   = 5;
    localparam int SCALED_W      = SENSOR_W + LEVEL_MUL_W;
    localparam int PROD_W        = RATIO_W + SPEED_W;

    localparam int DIV_NUM_W      = 32;
    localparam int DIV_DEN_W      = 16;
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = DIV_NUM_W / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam logic [PLANTER_PER_W-1:0] PLANTER_STOP = 16'hFFFF;
    localparam logic [PACKER_PER_W-1:0]  PACKER_STOP  = 8'hFF;
    localparam logic [SPEED_W-1:0]       SPEED_MAX    = 16'hFFFF;
    localparam logic [LEVEL_MUL_W-1:0]   LEVEL_MUL    = 5'd20;

    localparam logic [PLANTER_NUM_W-1:0] PLANTER_NUM_DEFAULT     = 32'd60000;
    localparam logic [PACKER_NUM_W-1:0]  PACKER_NUM_DEFAULT      = 16'd2550;
    localparam logic [LEVEL_INT_W-1:0]   LEVEL_FULL_SCALE_DEFAULT = 8'd20;

    typedef struct packed {
        logic [SENSOR_W-1:0]      left_sensor;
        logic [SENSOR_W-1:0]      right_sensor;
        logic [PLANTER_PER_W-1:0] planter_period;
        logic [PACKER_PER_W-1:0]  packer_period;
    } sample_t;

    typedef struct packed {
        logic [FAULT_W-1:0] fault_code;
        logic [LEVEL_W-1:0] left_level;
        logic [LEVEL_W-1:0] right_level;
        logic [SPEED_W-1:0] planter_speed;
        logic [SPEED_W-1:0] packer_speed;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
    } cfg_req_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] left_empty_cal;
        logic [SENSOR_W-1:0] left_full_cal;
        logic [SENSOR_W-1:0] right_empty_cal;
        logic [SENSOR_W-1:0] right_full_cal;
        logic [RATIO_W-1:0]  slip_factor;
        logic [LEVEL_W-1:0]  level_low_threshold;
        logic [LEVEL_W-1:0]  level_release_threshold;
        logic                speed_check_enable;
    } cfg_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEFT_EMPTY    = 3'd0,
        CFG_LEFT_FULL     = 3'd1,
        CFG_RIGHT_EMPTY   = 3'd2,
        CFG_RIGHT_FULL    = 3'd3,
        CFG_SLIP_FACTOR   = 3'd4,
        CFG_LOW_THRESH    = 3'd5,
        CFG_RELEASE_THRESH = 3'd6,
        CFG_SPEED_ENABLE  = 3'd7
    } cfg_index_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE         = 3'd0,
        FAULT_PLANTER_STOP = 3'd1,
        FAULT_PACKER_STOP  = 3'd2,
        FAULT_PLANTER_SLIP = 3'd3,
        FAULT_PACKER_SLIP  = 3'd4,
        FAULT_LOW_RIGHT    = 3'd5,
        FAULT_LOW_LEFT     = 3'd6
    } fault_t;

    typedef enum logic [1:0] {
        OP_PLANTER = 2'd0,
        OP_PACKER  = 2'd1,
        OP_LEFT    = 2'd2,
        OP_RIGHT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_START  = 2'd1,
        S_WAIT   = 2'd2,
        S_COMMIT = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_store;
        logic commit;
        op_t  op;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

>>> hw/rtl/sfm_chan_if.sv
// Valid/ready channel interface carrying one request payload.
interface sfm_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

>>> hw/rtl/sfm_cfg_regs.sv
// Configuration register file with write decode and reset values.
module sfm_cfg_regs
    import sfm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  cfg_req_t wr_req,
    output cfg_t     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_req.index))
                CFG_LEFT_EMPTY:     cfg_next.left_empty_cal = wr_req.value;
                CFG_LEFT_FULL:      cfg_next.left_full_cal = wr_req.value;
                CFG_RIGHT_EMPTY:    cfg_next.right_empty_cal = wr_req.value;
                CFG_RIGHT_FULL:     cfg_next.right_full_cal = wr_req.value;
                CFG_SLIP_FACTOR:    cfg_next.slip_factor = wr_req.value[RATIO_W-1:0];
                CFG_LOW_THRESH:     cfg_next.level_low_threshold = wr_req.value[LEVEL_W-1:0];
                CFG_RELEASE_THRESH:
                    cfg_next.level_release_threshold = wr_req.value[LEVEL_W-1:0];
                CFG_SPEED_ENABLE:   cfg_next.speed_check_enable = wr_req.value[0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_empty_cal          <= 8'd0;
            cfg_reg.left_full_cal           <= 8'd255;
            cfg_reg.right_empty_cal         <= 8'd0;
            cfg_reg.right_full_cal          <= 8'd255;
            cfg_reg.slip_factor             <= 4'd2;
            cfg_reg.level_low_threshold     <= 5'd4;
            cfg_reg.level_release_threshold <= 5'd6;
            cfg_reg.speed_check_enable      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/sfm_div.sv
// Iterative restoring divider producing four quotient bits per cycle.
module sfm_div
    import sfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quotient
);

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   step_rem;
    logic [DIV_NUM_W-1:0] step_quo;

    always_comb
    begin
        step_rem = {1'b0, rem_reg};
        step_quo = quo_reg;
        for (int i = 0; i < DIV_RADIX_BITS; i++)
        begin
            step_rem = {step_rem[DIV_DEN_W-1:0], step_quo[DIV_NUM_W-1]};
            step_quo = {step_quo[DIV_NUM_W-2:0], 1'b0};
            if (step_rem >= {1'b0, den_reg})
            begin
                step_rem    = step_rem - {1'b0, den_reg};
                step_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= step_quo;
            rem_reg <= step_rem[DIV_DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/sfm_datapath.sv
// Datapath: sample capture, divider operands, fault priority and result register.
module sfm_datapath
    import sfm_pkg::*;
#(
    parameter logic [PLANTER_NUM_W-1:0] PLANTER_SPEED_NUMERATOR = PLANTER_NUM_DEFAULT,
    parameter logic [PACKER_NUM_W-1:0]  PACKER_SPEED_NUMERATOR  = PACKER_NUM_DEFAULT,
    parameter logic [LEVEL_INT_W-1:0]   LEVEL_FULL_SCALE        = LEVEL_FULL_SCALE_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  sample_t    sample_data,
    input  cfg_t       cfg,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       result_valid,
    input  logic       result_ready,
    output result_t    result_data
);

    sample_t                smp_reg;
    logic [SPEED_W-1:0]     pl_q_reg;
    logic [SPEED_W-1:0]     pk_q_reg;
    logic [LEVEL_INT_W-1:0] lvl_l_reg;
    logic [LEVEL_INT_W-1:0] lvl_r_reg;
    logic                   right_low_reg;
    logic                   right_low_next;
    logic                   left_low_reg;
    logic                   left_low_next;
    logic                   out_valid_reg;
    result_t                out_reg;

    logic [SENSOR_W-1:0]  left_off;
    logic [SENSOR_W-1:0]  right_off;
    logic [SENSOR_W-1:0]  left_span;
    logic [SENSOR_W-1:0]  right_span;
    logic [SCALED_W-1:0]  left_scaled;
    logic [SCALED_W-1:0]  right_scaled;
    logic                 left_zero;
    logic                 right_zero;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [SPEED_W-1:0]   quo_sat;
    logic [LEVEL_INT_W-1:0] quo_level;

    logic                 pl_stop;
    logic                 pk_stop;
    logic [PROD_W-1:0]    pl_prod;
    logic [PROD_W-1:0]    pk_prod;
    fault_t               fault;

    assign left_off     = smp_reg.left_sensor - cfg.left_empty_cal;
    assign right_off    = smp_reg.right_sensor - cfg.right_empty_cal;
    assign left_span    = cfg.left_full_cal - cfg.left_empty_cal;
    assign right_span   = cfg.right_full_cal - cfg.right_empty_cal;
    assign left_scaled  = SCALED_W'(left_off) * SCALED_W'(LEVEL_MUL);
    assign right_scaled = SCALED_W'(right_off) * SCALED_W'(LEVEL_MUL);
    assign left_zero    = (smp_reg.left_sensor < cfg.left_empty_cal) || (left_span == '0);
    assign right_zero   = (smp_reg.right_sensor < cfg.right_empty_cal) || (right_span == '0);

    always_comb
    begin
        case (cmd.op)
            OP_PLANTER:
            begin
                div_num = DIV_NUM_W'(PLANTER_SPEED_NUMERATOR);
                div_den = DIV_DEN_W'(smp_reg.planter_period);
            end
            OP_PACKER:
            begin
                div_num = DIV_NUM_W'(PACKER_SPEED_NUMERATOR);
                div_den = DIV_DEN_W'(smp_reg.packer_period);
            end
            OP_LEFT:
            begin
                div_num = DIV_NUM_W'(left_scaled);
                div_den = DIV_DEN_W'(left_span);
            end
            default:
            begin
                div_num = DIV_NUM_W'(right_scaled);
                div_den = DIV_DEN_W'(right_span);
            end
        endcase
    end

    sfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // A zero period divides to all ones, which saturates like any overflow.
    assign quo_sat   = (|div_quo[DIV_NUM_W-1:SPEED_W]) ? SPEED_MAX : div_quo[SPEED_W-1:0];
    assign quo_level = (div_quo > DIV_NUM_W'(LEVEL_FULL_SCALE)) ? LEVEL_FULL_SCALE
                                                                : div_quo[LEVEL_INT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_reg <= sample_data;
        end
        if (cmd.div_store)
        begin
            case (cmd.op)
                OP_PLANTER: pl_q_reg <= quo_sat;
                OP_PACKER:  pk_q_reg <= quo_sat;
                OP_LEFT:    lvl_l_reg <= left_zero ? '0 : quo_level;
                default:    lvl_r_reg <= right_zero ? '0 : quo_level;
            endcase
        end
    end

    assign pl_stop = (smp_reg.planter_period == PLANTER_STOP);
    assign pk_stop = (smp_reg.packer_period == PACKER_STOP);
    assign pl_prod = PROD_W'(cfg.slip_factor) * PROD_W'(pl_q_reg);
    assign pk_prod = PROD_W'(cfg.slip_factor) * PROD_W'(pk_q_reg);

    always_comb
    begin
        fault          = FAULT_NONE;
        right_low_next = right_low_reg;
        left_low_next  = left_low_reg;
        if (pl_stop && !pk_stop)
        begin
            fault = FAULT_PLANTER_STOP;
        end
        else if (pk_stop && !pl_stop)
        begin
            fault = FAULT_PACKER_STOP;
        end
        else if (cfg.speed_check_enable && (PROD_W'(pk_q_reg) > pl_prod))
        begin
            fault = FAULT_PLANTER_SLIP;
        end
        else if (cfg.speed_check_enable && (PROD_W'(pl_q_reg) > pk_prod))
        begin
            fault = FAULT_PACKER_SLIP;
        end
        else if ((lvl_r_reg < LEVEL_INT_W'(cfg.level_low_threshold)) && !right_low_reg)
        begin
            fault          = FAULT_LOW_RIGHT;
            right_low_next = 1'b1;
        end
        else if ((lvl_l_reg < LEVEL_INT_W'(cfg.level_low_threshold)) && !left_low_reg)
        begin
            fault         = FAULT_LOW_LEFT;
            left_low_next = 1'b1;
        end
        else
        begin
            if (lvl_r_reg >= LEVEL_INT_W'(cfg.level_release_threshold))
            begin
                right_low_next = 1'b0;
            end
            if (lvl_l_reg >= LEVEL_INT_W'(cfg.level_release_threshold))
            begin
                left_low_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_low_reg <= 1'b0;
            left_low_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                right_low_reg <= right_low_next;
                left_low_reg  <= left_low_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.fault_code    <= fault;
            out_reg.left_level    <= lvl_l_reg[LEVEL_W-1:0];
            out_reg.right_level   <= lvl_r_reg[LEVEL_W-1:0];
            out_reg.planter_speed <= pl_stop ? '0 : pl_q_reg;
            out_reg.packer_speed  <= pk_stop ? '0 : pk_q_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || result_ready;
    assign result_valid    = out_valid_reg;
    assign result_data     = out_reg;

endmodule

>>> hw/rtl/sfm_ctrl.sv
// Controller state machine sequencing the four divisions and the result commit.
module sfm_ctrl
    import sfm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sample_valid,
    output logic       sample_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    op_t         op_reg;
    op_t         op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PLANTER;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        sample_ready  = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_store = 1'b0;
        cmd.commit    = 1'b0;
        cmd.op        = op_reg;
        case (state_reg)
            S_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_PLANTER;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (op_reg == OP_RIGHT)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        op_next    = op_t'(op_reg + 2'd1);
                        state_next = S_START;
                    end
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_starts_planter: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> state_reg == S_START && op_reg == OP_PLANTER)
        else $error("Accepted request did not start the planter division.");

    a_done_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_WAIT)
        else $error("Divider finished outside the wait state.");

    a_commit_after_last_op: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_COMMIT) |-> $past(op_reg) == OP_RIGHT)
        else $error("Commit reached before all four divisions finished.");
`endif

endmodule

>>> hw/rtl/seeder_fault_monitor_top.sv
// Seeder fault monitor top level: channels, configuration registers, control and datapath.
//
// The sample channel takes one request holding both hopper sensor bytes and
// both wheel pulse periods. The result channel returns one request per sample
// with the fault code, both fill levels and both wheel speeds. The cfg channel
// writes one configuration register per request; it is always ready and must
// only be used while no sample is in flight.
// A sample is taken only when the block is idle. The four divisions (planter
// speed, packer speed, left level, right level) run one after another on a
// single divider that yields four quotient bits per cycle.
// The result becomes valid once the right level division is done and the output
// register is free; a new sample is accepted only after that result is committed.
// The result sits in an output register, so the next sample is accepted while
// an earlier result waits; if the receiver stalls, the block holds the new
// result back until the old one is taken.
// Reset clears the state machine, the low-level latches and the result valid,
// and loads the configuration registers with their default values.
module seeder_fault_monitor_top
    import sfm_pkg::*;
#(
    parameter logic [PLANTER_NUM_W-1:0] PLANTER_SPEED_NUMERATOR = PLANTER_NUM_DEFAULT,
    parameter logic [PACKER_NUM_W-1:0]  PACKER_SPEED_NUMERATOR  = PACKER_NUM_DEFAULT,
    parameter logic [LEVEL_INT_W-1:0]   LEVEL_FULL_SCALE        = LEVEL_FULL_SCALE_DEFAULT
)
(
    input logic       clk,
    input logic       rst_n,
    sfm_chan_if.sink   sample,
    sfm_chan_if.source result,
    sfm_chan_if.sink   cfg
);

    cfg_t       cfg_vals;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       sample_ready;
    logic       result_valid;
    result_t    result_data;

    assign cfg.ready    = 1'b1;
    assign sample.ready = sample_ready;
    assign result.valid = result_valid;
    assign result.data  = result_data;

    sfm_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cfg.valid),
        .wr_req (cfg.data),
        .cfg    (cfg_vals)
    );

    sfm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample_ready),
        .cmd          (cmd),
        .status       (status)
    );

    sfm_datapath #(
        .PLANTER_SPEED_NUMERATOR (PLANTER_SPEED_NUMERATOR),
        .PACKER_SPEED_NUMERATOR  (PACKER_SPEED_NUMERATOR),
        .LEVEL_FULL_SCALE        (LEVEL_FULL_SCALE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_data  (sample.data),
        .cfg          (cfg_vals),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .result_data  (result_data)
    );

endmodule
